// ===== hw/rtl/pbts_pkg.sv =====
package pbts_pkg;

    localparam int unsigned OPCODE_W   = 2;
    localparam int unsigned TASK_ID_W  = 4;
    localparam int unsigned PRIO_REQ_W = 8;
    localparam int unsigned STATE_W    = 2;
    localparam int unsigned STATUS_W   = 3;

    localparam logic [OPCODE_W-1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SETSTATE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SCHEDULE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

    localparam logic [STATE_W-1:0] TS_READY      = 2'd0;
    localparam logic [STATE_W-1:0] TS_RUNNING    = 2'd1;
    localparam logic [STATE_W-1:0] TS_BLOCKED    = 2'd2;
    localparam logic [STATE_W-1:0] TS_TERMINATED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_KEEP     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FIRST    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SWITCH   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_SAME     = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_CHECK,
        S_REQUEUE,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/priority_bitmap_task_scheduler_core.sv =====
// Channel | Direction | Fields
// input   | in        | opcode, task_id, priority_req, new_state (i_valid / o_stall)
// result  | out       | status, next_task, prev_task, prev_valid (o_valid / i_stall)
//
// One item at a time: enqueue and set-state go through accept, decide and output steps;
// the result shows on o_valid once the output step loads the output register.
// A schedule adds a read and a check step for every task popped from the ready memory
// (its read port is registered), plus a requeue step when a task is chosen.
// Synchronous active-low reset clears level counters, bitmap, task state and current task.
// The ready-id memory needs no clearing; counts guard every read.
// The output register holds while i_stall is high; the next item is worked on meanwhile
// and waits in its output step until the register drains.
module priority_bitmap_task_scheduler_core #(
    parameter int unsigned PRIORITY_LEVELS = 8,
    parameter int unsigned TASK_COUNT      = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pbts_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic [pbts_pkg::TASK_ID_W-1:0]    i_task_id,
    input  logic [pbts_pkg::PRIO_REQ_W-1:0]   i_priority_req,
    input  logic [pbts_pkg::STATE_W-1:0]      i_new_state,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pbts_pkg::STATUS_W-1:0]     o_status,
    output logic [pbts_pkg::TASK_ID_W-1:0]    o_next_task,
    output logic [pbts_pkg::TASK_ID_W-1:0]    o_prev_task,
    output logic                              o_prev_valid
);
    import pbts_pkg::*;

    localparam int unsigned LW  = $clog2(PRIORITY_LEVELS);
    localparam int unsigned PW  = $clog2(TASK_COUNT);
    localparam int unsigned CW  = $clog2(TASK_COUNT + 1);
    localparam int unsigned AW  = LW + PW;
    localparam int unsigned TW  = TASK_ID_W;
    localparam logic [LW-1:0] TOP_LVL = LW'(PRIORITY_LEVELS - 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(TASK_COUNT - 1);

    t_state r_state, n_state;

    // per-level FIFO pointers, bitmap and per-task state
    logic [PW-1:0]           r_head  [PRIORITY_LEVELS];
    logic [PW-1:0]           r_tail  [PRIORITY_LEVELS];
    logic [CW-1:0]           r_count [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] r_bitmap;
    logic [STATE_W-1:0]      r_tstate [TASK_COUNT];
    logic [LW-1:0]           r_tprio  [TASK_COUNT];
    logic [TW-1:0]           r_cur;
    logic                    r_cur_valid;

    // latched item
    logic [OPCODE_W-1:0]   r_op;
    logic [TW-1:0]         r_id;
    logic [PRIO_REQ_W-1:0] r_prio;
    logic [STATE_W-1:0]    r_nst;
    logic [TW-1:0]         r_pick;

    logic [STATUS_W-1:0] r_status;
    logic [TW-1:0]       r_next, r_prev;
    logic                r_prev_valid;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [TW-1:0]       r_out_next, r_out_prev;
    logic                r_out_prev_valid;

    // ready-id memory
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [TW-1:0]   mem_wdata, mem_rdata;

    pbts_fifo_ram #(.DEPTH(1 << AW), .WIDTH(TW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // highest set bitmap bit
    logic [LW-1:0] top_lvl;
    always_comb begin
        top_lvl = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (r_bitmap[i]) begin
                top_lvl = LW'(i);
            end
        end
    end

    logic id_ok, cur_ok, cur_run, pick_ok;
    logic [LW-1:0] enq_lvl, cur_lvl;
    assign id_ok   = (32'(r_id) < TASK_COUNT);
    assign cur_ok  = (32'(r_cur) < TASK_COUNT);
    assign cur_run = r_cur_valid && cur_ok && (r_tstate[PW'(r_cur)] == TS_RUNNING);
    assign pick_ok = (32'(mem_rdata) < TASK_COUNT)
                  && (r_tstate[PW'(mem_rdata)] != TS_TERMINATED);
    assign enq_lvl = (32'(r_prio) >= PRIORITY_LEVELS) ? TOP_LVL : LW'(r_prio);
    assign cur_lvl = r_tprio[PW'(r_cur)];

    logic accept_in;
    assign accept_in = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE);

    // load the output register once it is empty or draining
    logic out_load;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_valid) n_state = S_DECIDE;
            S_DECIDE:  begin
                if (r_op == OP_SCHEDULE && r_bitmap != '0) n_state = S_READ;
                else n_state = S_OUT;
            end
            S_READ:    n_state = S_CHECK;
            S_CHECK:   begin
                if (pick_ok) n_state = S_REQUEUE;
                else if (r_bitmap != '0) n_state = S_READ;
                else n_state = S_OUT;
            end
            S_REQUEUE: n_state = S_OUT;
            S_OUT:     if (out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {enq_lvl, r_tail[enq_lvl]};
        mem_wdata = r_id;
        mem_raddr = {top_lvl, r_head[top_lvl]};
        if (r_state == S_DECIDE && r_op == OP_ENQUEUE && id_ok
            && r_tstate[PW'(r_id)] != TS_TERMINATED
            && 32'(r_count[enq_lvl]) < TASK_COUNT) begin
            mem_we = 1'b1;
        end
        if (r_state == S_REQUEUE) begin
            mem_waddr = {cur_lvl, r_tail[cur_lvl]};
            mem_wdata = r_cur;
            mem_we    = cur_run && (32'(r_count[cur_lvl]) < TASK_COUNT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_op   <= i_opcode;
            r_id   <= i_task_id;
            r_prio <= i_priority_req;
            r_nst  <= i_new_state;
            r_prev       <= r_cur;
            r_prev_valid <= r_cur_valid;
        end
        if (r_state == S_CHECK) begin
            r_pick <= mem_rdata;
        end
        if (out_load) begin
            r_out_status     <= r_status;
            r_out_next       <= r_next;
            r_out_prev       <= r_prev;
            r_out_prev_valid <= r_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bitmap    <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= ST_IGNORED;
            r_next      <= '0;
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            for (int t = 0; t < TASK_COUNT; t++) begin
                r_tstate[t] <= TS_READY;
                r_tprio[t]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_DECIDE: begin
                    r_next <= '0;
                    if (r_op == OP_ENQUEUE && id_ok
                        && r_tstate[PW'(r_id)] != TS_TERMINATED) begin
                        if (mem_we) begin
                            r_tail[enq_lvl]  <= (r_tail[enq_lvl] == LAST_PTR)
                                              ? '0 : r_tail[enq_lvl] + 1'b1;
                            r_count[enq_lvl] <= r_count[enq_lvl] + 1'b1;
                            r_bitmap[enq_lvl] <= 1'b1;
                            r_tprio[PW'(r_id)] <= enq_lvl;
                            r_status <= ST_ACCEPTED;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end else if (r_op == OP_SETSTATE && id_ok) begin
                        r_tstate[PW'(r_id)] <= r_nst;
                        r_status <= ST_ACCEPTED;
                    end else if (r_op == OP_SCHEDULE && r_bitmap == '0) begin
                        r_status <= cur_run ? ST_KEEP : ST_IDLE;
                    end else begin
                        r_status <= ST_IGNORED;
                    end
                end
                S_READ: begin
                    // pop head of top level while the read is in flight
                    r_head[top_lvl]  <= (r_head[top_lvl] == LAST_PTR)
                                      ? '0 : r_head[top_lvl] + 1'b1;
                    r_count[top_lvl] <= r_count[top_lvl] - 1'b1;
                    if (r_count[top_lvl] == CW'(1)) begin
                        r_bitmap[top_lvl] <= 1'b0;
                    end
                end
                S_CHECK: begin
                    if (!pick_ok && r_bitmap == '0) begin
                        r_status <= cur_run ? ST_KEEP : ST_IDLE;
                    end
                end
                S_REQUEUE: begin
                    if (cur_run) begin
                        // the chosen task ends up running even if it is the current one
                        if (r_cur != r_pick) begin
                            r_tstate[PW'(r_cur)] <= TS_READY;
                        end
                        if (mem_we) begin
                            r_tail[cur_lvl]  <= (r_tail[cur_lvl] == LAST_PTR)
                                              ? '0 : r_tail[cur_lvl] + 1'b1;
                            r_count[cur_lvl] <= r_count[cur_lvl] + 1'b1;
                            r_bitmap[cur_lvl] <= 1'b1;
                        end
                    end
                    r_tstate[PW'(r_pick)] <= TS_RUNNING;
                    if (r_cur_valid && r_cur == r_pick) r_status <= ST_SAME;
                    else if (!r_cur_valid) r_status <= ST_FIRST;
                    else r_status <= ST_SWITCH;
                    r_cur       <= r_pick;
                    r_cur_valid <= 1'b1;
                    r_next      <= r_pick;
                end
                default: ;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_next_task  = r_out_next;
    assign o_prev_task  = r_out_prev;
    assign o_prev_valid = r_out_prev_valid;

endmodule

// ===== hw/rtl/pbts_fifo_ram.sv =====
module pbts_fifo_ram #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned WIDTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
